FILE: rtl/co2_pkg.sv
// Package: types, codes and CRC function for the CO2 sensor poll sequencer
`timescale 1ns / 1ps
package co2_pkg;
    localparam int TIME_W = 48;
    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [15:0] READY_MASK = 16'h07FF;
    localparam logic [15:0] PPM_MAX = 16'd40000;
    localparam logic [15:0] CMD_START = 16'h21B1;
    localparam logic [15:0] CMD_START_LP = 16'h21AC;
    localparam logic [15:0] CMD_READ_MEAS = 16'hEC05;
    localparam logic [15:0] CMD_STOP = 16'h3F86;
    localparam logic [15:0] CMD_DATA_READY = 16'hE4B8;
    localparam logic [15:0] CMD_SERIAL = 16'h3682;

    localparam logic [1:0] R_READY = 2'd0;
    localparam logic [1:0] R_RETRY = 2'd1;
    localparam logic [1:0] R_NOTPRES = 2'd2;
    localparam logic [1:0] R_ERROR = 2'd3;

    localparam logic [3:0] S_DETACHED = 4'd0;
    localparam logic [3:0] S_PROBING = 4'd1;
    localparam logic [3:0] S_STARTING = 4'd2;
    localparam logic [3:0] S_WARMING = 4'd3;
    localparam logic [3:0] S_WAITING = 4'd4;
    localparam logic [3:0] S_READING = 4'd5;
    localparam logic [3:0] S_READY = 4'd6;
    localparam logic [3:0] S_REPROBE = 4'd7;
    localparam logic [3:0] S_UNINIT = 4'd8;

    localparam logic [2:0] P_SEND = 3'd0;
    localparam logic [2:0] P_READ = 3'd1;
    localparam logic [2:0] P_AFTER_STOP = 3'd2;
    localparam logic [2:0] P_STAT_CMD = 3'd3;
    localparam logic [2:0] P_STAT_RSP = 3'd4;
    localparam logic [2:0] P_MEAS_RSP = 3'd5;

    localparam logic [3:0] Q_MISSING = 4'd1;
    localparam logic [3:0] Q_CRC = 4'd2;
    localparam logic [3:0] Q_RANGE = 4'd4;
    localparam logic [3:0] Q_STALE = 4'd8;

    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_ACQUIRE = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [2:0] BUS_OK = 3'd0;
    localparam logic [2:0] BUS_ABSENT = 3'd1;
    localparam logic [2:0] BUS_BUSY = 3'd2;
    localparam logic [2:0] BUS_TIMEOUT = 3'd3;
    localparam logic [2:0] BUS_IO = 3'd4;

    localparam logic [1:0] CFG_POLL = 2'd0;
    localparam logic [1:0] CFG_LOWPOWER = 2'd1;
    localparam logic [1:0] CFG_ADDRESS = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] now_ms;
        logic [2:0]  write_status;
        logic [2:0]  stop_status;
        logic [2:0]  read_status;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic        ok_a;
        logic        ok_b;
        logic        ok_c;
    } item_t;

    typedef struct packed {
        logic [15:0] command_sent;
        logic        stop_sent;
        logic [3:0]  read_bytes;
        logic [1:0]  driver_result;
        logic [3:0]  state_code;
        logic        sample_valid;
        logic [15:0] co2_ppm;
        logic [3:0]  qual_bits;
        logic [47:0] sample_time_ms;
        logic [31:0] start_count;
        logic [47:0] last_attempt_ms;
    } result_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  driver_state;
        logic        probed;
        logic        has_last_good;
        logic        reprobe_owed;
        logic        has_sample;
        logic [47:0] next_action_ms;
        logic [47:0] attempt_ms;
        logic [15:0] current_ppm;
        logic [15:0] good_ppm;
        logic [47:0] current_time;
        logic [47:0] good_time;
        logic [3:0]  flags;
        logic [1:0]  failure_code;
        logic [31:0] starts;
    } state_t;

    function automatic state_t reset_state();
        state_t st;
        st = '0;
        st.phase = P_SEND;
        st.driver_state = S_UNINIT;
        st.failure_code = R_ERROR;
        return st;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [15:0] w);
        logic [7:0] crc;
        crc = CRC_INIT;
        for (int b = 0; b < 2; b++) begin
            crc = crc ^ ((b == 0) ? w[15:8] : w[7:0]);
            for (int i = 0; i < 8; i++) begin
                crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
            end
        end
        return crc;
    endfunction

    function automatic logic [1:0] map_bus(input logic [2:0] s);
        logic [1:0] r;
        case (s)
            BUS_OK:      r = R_READY;
            BUS_ABSENT:  r = R_NOTPRES;
            BUS_BUSY:    r = R_RETRY;
            BUS_TIMEOUT: r = R_RETRY;
            default:     r = R_ERROR;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? '1 : s[47:0];
    endfunction
endpackage

FILE: rtl/co2_sensor_poll_sequencer_unit.sv
// Top level of the CO2 sensor poll sequencer
`timescale 1ns / 1ps
// One result item per input item. An item passes the input register, then the
// combinational decision logic against the driver state, into the result register;
// one item per cycle sustained while m_axis_tready does not stall. The input register is
// refilled whenever the result register is empty or being drained.
module co2_sensor_poll_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // now_ms, write_status, stop_status, read_status,
                                        // word_a, crc_a, word_b, crc_b, word_c, crc_c
    input  logic [1:0]   s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata,  // command_sent, stop_sent, read_bytes, driver_result,
                                        // state_code, sample_valid, co2_ppm, qual_bits,
                                        // sample_time_ms, start_count, last_attempt_ms
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            adv;
    logic            load;
    logic [31:0]     poll_reg;
    logic            lp_reg;
    logic [6:0]      addr_reg;
    co2_pkg::item_t  item;
    co2_pkg::result_t result;
    co2_pkg::result_t out_reg;

    assign adv = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign load = s_axis_tvalid && s_axis_tready;

    co2_front u_front (
        .clk(clk), .rst_n(rst_n), .load(load),
        .operation(s_axis_tuser), .data(s_axis_tdata[128:0]), .item(item)
    );

    co2_core u_core (
        .clk(clk), .rst_n(rst_n), .step(adv), .item(item),
        .poll_period(poll_reg), .low_power_mode(lp_reg), .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            poll_reg <= 32'd5000;
            lp_reg <= 1'b0;
            addr_reg <= 7'd98;
        end
        else
        begin
            if (load) in_valid_reg <= 1'b1;
            else if (adv) in_valid_reg <= 1'b0;
            if (adv) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    co2_pkg::CFG_POLL:     poll_reg <= cfg_data;
                    co2_pkg::CFG_LOWPOWER: lp_reg <= cfg_data[0];
                    co2_pkg::CFG_ADDRESS:  addr_reg <= cfg_data[6:0];
                    default:               poll_reg <= poll_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {(addr_reg != 7'd0) & 1'b0, 1'b0, 6'd0, out_reg.last_attempt_ms,
                           out_reg.start_count, out_reg.sample_time_ms,
                           out_reg.qual_bits, out_reg.co2_ppm, out_reg.sample_valid,
                           out_reg.state_code, out_reg.driver_result, out_reg.read_bytes,
                           out_reg.stop_sent, out_reg.command_sent};
endmodule

FILE: rtl/co2_front.sv
// Input register stage with CRC checks of the three response words
`timescale 1ns / 1ps
module co2_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [1:0]           operation,
    input  logic [128:0]         data,
    output co2_pkg::item_t       item
);
    co2_pkg::item_t item_reg;
    co2_pkg::item_t item_next;

    always_comb
    begin
        item_next.operation    = operation;
        item_next.now_ms       = data[47:0];
        item_next.write_status = data[50:48];
        item_next.stop_status  = data[53:51];
        item_next.read_status  = data[56:54];
        item_next.word_a       = data[72:57];
        item_next.word_b       = data[96:81];
        item_next.ok_a = co2_pkg::crc8_word(data[72:57]) == data[80:73];
        item_next.ok_b = co2_pkg::crc8_word(data[96:81]) == data[104:97];
        item_next.ok_c = co2_pkg::crc8_word(data[120:105]) == data[128:121];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;
endmodule

FILE: rtl/co2_core.sv
// Driver state register and next-state logic for one item
`timescale 1ns / 1ps
module co2_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  co2_pkg::item_t  item,
    input  logic [31:0]     poll_period,
    input  logic            low_power_mode,
    output co2_pkg::result_t result
);
    co2_pkg::state_t st_reg;
    co2_pkg::state_t st_next;
    co2_pkg::state_t s;
    logic [15:0] cmd;
    logic        stp;
    logic [3:0]  rb;
    logic [1:0]  res;
    logic [2:0]  ws, ss, rs;
    logic        all_ok;
    logic [1:0]  r;

    always_comb
    begin
        s = st_reg;
        cmd = '0;
        stp = 1'b0;
        rb = '0;
        res = co2_pkg::R_ERROR;
        ws = item.write_status;
        ss = item.stop_status;
        rs = item.read_status;
        all_ok = item.ok_a & item.ok_b & item.ok_c;
        r = co2_pkg::map_bus(ws);
        case (item.operation)
            co2_pkg::OP_PROBE:
            begin
                if (s.probed)
                begin
                    res = co2_pkg::R_READY;
                end
                else
                begin
                    if (s.phase == co2_pkg::P_AFTER_STOP) s.phase = co2_pkg::P_SEND;
                    if (s.phase == co2_pkg::P_SEND)
                    begin
                        s.driver_state = co2_pkg::S_PROBING;
                        cmd = co2_pkg::CMD_SERIAL;
                        if (ws == co2_pkg::BUS_OK)
                        begin
                            s.phase = co2_pkg::P_READ;
                            res = co2_pkg::R_RETRY;
                        end
                        else if (ws == co2_pkg::BUS_ABSENT || ws == co2_pkg::BUS_IO)
                        begin
                            stp = 1'b1;
                            if (ss == co2_pkg::BUS_OK)
                            begin
                                s.phase = co2_pkg::P_AFTER_STOP;
                                res = co2_pkg::R_RETRY;
                            end
                            else
                            begin
                                res = co2_pkg::map_bus(ss);
                            end
                        end
                        else
                        begin
                            res = r;
                        end
                    end
                    else if (s.phase != co2_pkg::P_READ)
                    begin
                        s.probed = 1'b0;
                        s.phase = co2_pkg::P_SEND;
                        s.driver_state = co2_pkg::S_REPROBE;
                        res = co2_pkg::R_ERROR;
                    end
                    else
                    begin
                        rb = 4'd9;
                        if (rs != co2_pkg::BUS_OK)
                        begin
                            s.phase = co2_pkg::P_SEND;
                            res = co2_pkg::map_bus(rs);
                        end
                        else if (!all_ok)
                        begin
                            s.probed = 1'b0;
                            s.phase = co2_pkg::P_SEND;
                            s.driver_state = co2_pkg::S_REPROBE;
                            res = co2_pkg::R_ERROR;
                        end
                        else
                        begin
                            cmd = low_power_mode ? co2_pkg::CMD_START_LP : co2_pkg::CMD_START;
                            if (ws != co2_pkg::BUS_OK)
                            begin
                                s.probed = 1'b0;
                                s.phase = co2_pkg::P_SEND;
                                s.driver_state = co2_pkg::S_REPROBE;
                                res = r;
                            end
                            else
                            begin
                                if (s.starts != '1) s.starts = s.starts + 32'd1;
                                s.probed = 1'b1;
                                s.driver_state = co2_pkg::S_WARMING;
                                s.phase = co2_pkg::P_STAT_CMD;
                                s.next_action_ms = '0;
                                s.failure_code = co2_pkg::R_ERROR;
                                res = co2_pkg::R_READY;
                            end
                        end
                    end
                end
            end
            co2_pkg::OP_ACQUIRE:
            begin
                logic       fail;
                logic [3:0] fflag;
                logic [1:0] fres;
                logic       wait_ag;
                fail = 1'b0;
                fflag = '0;
                fres = co2_pkg::R_ERROR;
                wait_ag = 1'b0;
                if (s.reprobe_owed)
                begin
                    s.reprobe_owed = 1'b0;
                    s.has_sample = 1'b0;
                    res = s.failure_code;
                end
                else if (!s.probed)
                begin
                    res = co2_pkg::R_NOTPRES;
                end
                else if (item.now_ms < s.next_action_ms)
                begin
                    res = co2_pkg::R_RETRY;
                end
                else if (s.phase == co2_pkg::P_STAT_RSP)
                begin
                    rb = 4'd3;
                    if (rs == co2_pkg::BUS_BUSY || rs == co2_pkg::BUS_TIMEOUT)
                        res = co2_pkg::R_RETRY;
                    else if (rs != co2_pkg::BUS_OK)
                    begin
                        fail = 1'b1;
                        fflag = (rs == co2_pkg::BUS_ABSENT) ? co2_pkg::Q_MISSING : 4'd0;
                        fres = (rs == co2_pkg::BUS_ABSENT) ? co2_pkg::R_NOTPRES
                                                           : co2_pkg::R_ERROR;
                    end
                    else if (!item.ok_a)
                    begin
                        fail = 1'b1;
                        fflag = co2_pkg::Q_CRC;
                    end
                    else if ((item.word_a & co2_pkg::READY_MASK) == 16'd0)
                        wait_ag = 1'b1;
                    else
                    begin
                        cmd = co2_pkg::CMD_READ_MEAS;
                        if (ws != co2_pkg::BUS_OK)
                        begin
                            if (r == co2_pkg::R_RETRY) wait_ag = 1'b1;
                            else
                            begin
                                fail = 1'b1;
                                fflag = (ws == co2_pkg::BUS_ABSENT) ? co2_pkg::Q_MISSING
                                                                    : 4'd0;
                                fres = r;
                            end
                        end
                        else
                        begin
                            s.phase = co2_pkg::P_MEAS_RSP;
                            s.next_action_ms = co2_pkg::add_sat(item.now_ms, 32'd1);
                            s.driver_state = co2_pkg::S_READING;
                            res = co2_pkg::R_RETRY;
                        end
                    end
                end
                else if (s.phase == co2_pkg::P_MEAS_RSP)
                begin
                    rb = 4'd9;
                    if (rs == co2_pkg::BUS_BUSY || rs == co2_pkg::BUS_TIMEOUT)
                        res = co2_pkg::R_RETRY;
                    else if (rs != co2_pkg::BUS_OK)
                    begin
                        fail = 1'b1;
                        fflag = (rs == co2_pkg::BUS_ABSENT) ? co2_pkg::Q_MISSING : 4'd0;
                        fres = (rs == co2_pkg::BUS_ABSENT) ? co2_pkg::R_NOTPRES
                                                           : co2_pkg::R_ERROR;
                    end
                    else if (!all_ok)
                    begin
                        fail = 1'b1;
                        fflag = co2_pkg::Q_CRC;
                    end
                    else if (item.word_a == 16'd0 || item.word_a > co2_pkg::PPM_MAX)
                    begin
                        fail = 1'b1;
                        fflag = co2_pkg::Q_RANGE;
                    end
                    else
                    begin
                        s.current_ppm = item.word_a;
                        s.good_ppm = item.word_a;
                        s.current_time = item.now_ms;
                        s.good_time = item.now_ms;
                        s.attempt_ms = item.now_ms;
                        s.flags = '0;
                        s.failure_code = co2_pkg::R_READY;
                        s.has_sample = 1'b1;
                        s.has_last_good = 1'b1;
                        s.reprobe_owed = 1'b0;
                        s.driver_state = co2_pkg::S_READY;
                        s.phase = co2_pkg::P_STAT_CMD;
                        s.next_action_ms = co2_pkg::add_sat(item.now_ms, poll_period);
                        res = co2_pkg::R_READY;
                    end
                end
                else if (s.phase != co2_pkg::P_STAT_CMD)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    s.attempt_ms = item.now_ms;
                    cmd = co2_pkg::CMD_DATA_READY;
                    if (ws == co2_pkg::BUS_BUSY || ws == co2_pkg::BUS_TIMEOUT)
                        res = co2_pkg::R_RETRY;
                    else if (ws != co2_pkg::BUS_OK)
                    begin
                        fail = 1'b1;
                        fflag = (ws == co2_pkg::BUS_ABSENT) ? co2_pkg::Q_MISSING : 4'd0;
                        fres = (ws == co2_pkg::BUS_ABSENT) ? co2_pkg::R_NOTPRES
                                                           : co2_pkg::R_ERROR;
                    end
                    else
                    begin
                        s.phase = co2_pkg::P_STAT_RSP;
                        s.next_action_ms = co2_pkg::add_sat(item.now_ms, 32'd1);
                        s.driver_state = s.has_last_good ? co2_pkg::S_WAITING
                                                         : co2_pkg::S_WARMING;
                        res = co2_pkg::R_RETRY;
                    end
                end
                if (wait_ag)
                begin
                    s.phase = co2_pkg::P_STAT_CMD;
                    s.next_action_ms = co2_pkg::add_sat(item.now_ms, poll_period);
                    s.driver_state = s.has_last_good ? co2_pkg::S_WAITING
                                                     : co2_pkg::S_WARMING;
                    res = co2_pkg::R_RETRY;
                end
                if (fail)
                begin
                    s.attempt_ms = item.now_ms;
                    s.flags = fflag;
                    s.failure_code = fres;
                    s.has_sample = 1'b0;
                    s.probed = 1'b0;
                    s.phase = co2_pkg::P_SEND;
                    s.driver_state = co2_pkg::S_REPROBE;
                    res = fres;
                    if (s.has_last_good)
                    begin
                        s.current_ppm = s.good_ppm;
                        s.current_time = s.good_time;
                        s.flags = fflag | co2_pkg::Q_STALE;
                        s.has_sample = 1'b1;
                        s.reprobe_owed = 1'b1;
                        res = co2_pkg::R_READY;
                    end
                end
            end
            co2_pkg::OP_RESET:
            begin
                s.driver_state = co2_pkg::S_DETACHED;
                s.phase = co2_pkg::P_SEND;
                s.next_action_ms = '0;
                s.current_time = '0;
                s.good_time = '0;
                s.attempt_ms = '0;
                s.current_ppm = '0;
                s.good_ppm = '0;
                s.flags = '0;
                s.failure_code = co2_pkg::R_ERROR;
                s.probed = 1'b0;
                s.has_sample = 1'b0;
                s.has_last_good = 1'b0;
                s.reprobe_owed = 1'b0;
                res = co2_pkg::R_READY;
            end
            default:
            begin
                res = co2_pkg::R_ERROR;
            end
        endcase
        st_next = s;
        result.command_sent = cmd;
        result.stop_sent = stp;
        result.read_bytes = rb;
        result.driver_result = res;
        result.state_code = s.driver_state;
        result.sample_valid = s.has_sample;
        result.co2_ppm = s.has_sample ? s.current_ppm : 16'd0;
        result.qual_bits = s.flags;
        result.sample_time_ms = s.has_sample ? s.current_time : 48'd0;
        result.start_count = s.starts;
        result.last_attempt_ms = s.attempt_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= co2_pkg::reset_state();
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end
endmodule

FILE: rtl/co2_checker.sv
// Port checker for the CO2 sensor poll sequencer, bound to the top level
`timescale 1ns / 1ps
module co2_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_nosample: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[27] |-> m_axis_tdata[43:28] == 16'd0)
        else $error("ppm shown without sample");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[43:28] <= 16'd40000)
        else $error("ppm out of range");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind co2_sensor_poll_sequencer_unit co2_checker u_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
